/* hw/rtl/ssg_pkg.sv */
// Package for the separable Sobel gradient block: field widths, register
// indexes, result slot positions and the packed types shared by the RTL.
// No dependencies.
package ssg_pkg;

    localparam int PIX_W            = 8;
    localparam int CFG_W            = 12;
    localparam int CFG_IDX_W        = 1;
    localparam int GX_W             = 11;
    localparam int GY_W             = 9;
    localparam int POS_W            = 11;
    localparam int NRES             = 4;
    localparam int OUT_PAY_W        = GX_W + GY_W + POS_W + POS_W;
    localparam int OUT_DATA_W       = ((OUT_PAY_W + 7) / 8) * 8;
    localparam int Q_AW             = 2;
    localparam int Q_DEPTH          = 2 ** Q_AW;
    localparam int Q_CW             = Q_AW + 1;
    localparam int IMAGE_WIDTH_RST  = 640;
    localparam int IMAGE_HEIGHT_RST = 480;
    localparam int MIN_DIM          = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_index;

    // result slots of one input, in output order
    localparam int RES_UPPER      = 0;  // row r-1, column c-1
    localparam int RES_UPPER_EDGE = 1;  // row r-1, column c (row end)
    localparam int RES_LOWER      = 2;  // row r, column c-1 (last row)
    localparam int RES_LOWER_EDGE = 3;  // row r, column c (last row, row end)

    typedef struct packed {
        logic [PIX_W-1:0] two;
        logic [PIX_W-1:0] one;
    } t_line;

    typedef struct packed {
        logic [PIX_W-1:0] two;
        logic [PIX_W-1:0] one;
        logic [PIX_W-1:0] cur;
    } t_col;

    typedef struct packed {
        logic [NRES-1:0]  mask;
        logic             top;
        logic             col_ge2;
        logic             col_is1;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } t_ctrl;

    typedef struct packed {
        logic signed [GX_W-1:0] gx_upper;
        logic signed [GX_W-1:0] gx_lower;
        logic signed [GY_W-1:0] gy_upper;
        logic signed [GY_W-1:0] gy_edge;
        logic [POS_W-1:0]       row;
        logic [POS_W-1:0]       col;
        logic [NRES-1:0]        mask;
    } t_set;

endpackage

/* hw/rtl/separable_sobel_gradients.sv */
// Top level of the separable Sobel gradient block: line memory, column window,
// gradient stage, result set queue and output register. Uses ssg_pkg.
//
// channel  dir  handshake                        payload
// s_axis   in   i_s_axis_tvalid/o_s_axis_tready  tdata[7:0] pixel
// m_axis   out  o_m_axis_tvalid/i_m_axis_tready  tdata gradients and position, tlast
// cfg      in   i_cfg_valid/o_cfg_ready          i_cfg_index, i_cfg_data
//
// One pixel per cycle while each pixel yields at most one result and m_axis is not
// stalled; a pixel with k results takes k transfers of the single output register,
// buffered by a 4-set queue; results reach the output register through that queue.
// The line memory holds the two rows above, one read and one write per pixel.
// Reset clears counters and control; the line memory is not cleared.
// Output stalls fill the set queue; tready drops when queue plus pipeline hold 4.
module separable_sobel_gradients #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [ssg_pkg::PIX_W-1:0]          i_s_axis_tdata,  // [7:0] pixel
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [10:0] grad_x_quarters, [19:11] grad_y, [30:20] out_row, [41:31] out_col
    output logic [ssg_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    output logic                               o_m_axis_tlast,  // last_of_run
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ssg_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ssg_pkg::CFG_W-1:0]          i_cfg_data
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int PW    = ssg_pkg::POS_W;
    localparam int QAW   = ssg_pkg::Q_AW;
    localparam int QCW   = ssg_pkg::Q_CW;
    localparam int NR    = ssg_pkg::NRES;
    localparam int PAD_W = ssg_pkg::OUT_DATA_W - ssg_pkg::OUT_PAY_W;
    localparam int W_RST = (ssg_pkg::IMAGE_WIDTH_RST > MAX_WIDTH) ?
                           MAX_WIDTH : ssg_pkg::IMAGE_WIDTH_RST;
    localparam int H_RST = (ssg_pkg::IMAGE_HEIGHT_RST > MAX_HEIGHT) ?
                           MAX_HEIGHT : ssg_pkg::IMAGE_HEIGHT_RST;
    localparam logic [CW-1:0] COL_LAST_RST = CW'(W_RST - 1);
    localparam logic [RW-1:0] ROW_LAST_RST = RW'(H_RST - 1);

    function automatic logic signed [9:0] f_diff(input logic [7:0] lo_px,
                                                 input logic [7:0] hi_px,
                                                 input logic       en);
        logic signed [9:0] d;
        d = $signed({2'b00, hi_px}) - $signed({2'b00, lo_px});
        return en ? d : 10'sd0;
    endfunction

    function automatic logic [7:0] f_smooth(input logic [7:0] a_px,
                                            input logic [7:0] b_px,
                                            input logic [7:0] d_px,
                                            input logic       at_first);
        logic [9:0] sum4;
        logic [8:0] sum2;
        sum4 = {2'b00, a_px} + {1'b0, b_px, 1'b0} + {2'b00, d_px};
        sum2 = {1'b0, b_px} + {1'b0, d_px};
        return at_first ? sum2[8:1] : sum4[9:2];
    endfunction

    function automatic logic [7:0] f_pair(input logic [7:0] a_px,
                                          input logic [7:0] b_px);
        logic [8:0] sum2;
        sum2 = {1'b0, a_px} + {1'b0, b_px};
        return sum2[8:1];
    endfunction

    function automatic logic signed [8:0] f_sdiff(input logic [7:0] x_px,
                                                  input logic [7:0] y_px);
        return $signed({1'b0, x_px}) - $signed({1'b0, y_px});
    endfunction

    // configuration
    logic          cfg_fire;
    logic [CW-1:0] r_col_last, n_col_last;
    logic [RW-1:0] r_row_last, n_row_last;

    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid & o_cfg_ready;

    always_comb begin
        if (int'(i_cfg_data) < ssg_pkg::MIN_DIM) begin
            n_col_last = CW'(ssg_pkg::MIN_DIM - 1);
            n_row_last = RW'(ssg_pkg::MIN_DIM - 1);
        end else begin
            n_col_last = (int'(i_cfg_data) > MAX_WIDTH) ?
                         CW'(MAX_WIDTH - 1) : CW'(int'(i_cfg_data) - 1);
            n_row_last = (int'(i_cfg_data) > MAX_HEIGHT) ?
                         RW'(MAX_HEIGHT - 1) : RW'(int'(i_cfg_data) - 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_last <= COL_LAST_RST;
            r_row_last <= ROW_LAST_RST;
        end else if (cfg_fire) begin
            case (i_cfg_index)
                ssg_pkg::CFG_IMAGE_WIDTH: begin
                    r_col_last <= n_col_last;
                end
                ssg_pkg::CFG_IMAGE_HEIGHT: begin
                    r_row_last <= n_row_last;
                end
                default: begin
                end
            endcase
        end
    end

    // input side and position counters
    logic           in_fire, row_end, last_row, row_nz, col_nz;
    logic [CW-1:0]  r_col;
    logic [RW-1:0]  r_row;
    logic [QCW-1:0] r_q_count, inflight;
    logic           r_s1_valid, r_s2_valid;
    ssg_pkg::t_ctrl n_ctrl, r_s1_ctrl, r_s2_ctrl;

    assign inflight        = r_q_count + QCW'(r_s1_valid) + QCW'(r_s2_valid);
    assign o_s_axis_tready = inflight < QCW'(ssg_pkg::Q_DEPTH);
    assign in_fire         = i_s_axis_tvalid & o_s_axis_tready;
    assign row_end         = r_col >= r_col_last;
    assign last_row        = r_row >= r_row_last;
    assign row_nz          = r_row != '0;
    assign col_nz          = r_col != '0;

    always_comb begin
        n_ctrl = '0;
        n_ctrl.mask[ssg_pkg::RES_UPPER]      = row_nz & col_nz;
        n_ctrl.mask[ssg_pkg::RES_UPPER_EDGE] = row_nz & row_end;
        n_ctrl.mask[ssg_pkg::RES_LOWER]      = row_nz & last_row & col_nz;
        n_ctrl.mask[ssg_pkg::RES_LOWER_EDGE] = row_nz & last_row & row_end;
        n_ctrl.top     = r_row == RW'(1);
        n_ctrl.col_ge2 = r_col > CW'(1);
        n_ctrl.col_is1 = r_col == CW'(1);
        n_ctrl.row     = PW'(r_row);
        n_ctrl.col     = PW'(r_col);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_fire) begin
            if (row_end) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // line memory: read column at accept, write it back in the cycle after
    ssg_pkg::t_line              r_line_mem [MAX_WIDTH];
    ssg_pkg::t_line              r_line_rd, n_line_wr;
    logic [ssg_pkg::PIX_W-1:0]   r_s1_pixel;
    logic [CW-1:0]               r_s1_col;

    assign n_line_wr.two = r_line_rd.one;
    assign n_line_wr.one = r_s1_pixel;

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_line_rd <= r_line_mem[r_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_line_mem[r_s1_col] <= n_line_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_fire;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_pixel <= i_s_axis_tdata;
            r_s1_col   <= r_col;
            r_s1_ctrl  <= n_ctrl;
        end
        if (r_s1_valid) begin
            r_s2_ctrl <= r_s1_ctrl;
        end
    end

    // column window, index 0 holds the newest column
    ssg_pkg::t_col r_win [3];
    ssg_pkg::t_col n_win_new;

    assign n_win_new.two = r_line_rd.two;
    assign n_win_new.one = r_line_rd.one;
    assign n_win_new.cur = r_s1_pixel;

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_win[2] <= r_win[1];
            r_win[1] <= r_win[0];
            r_win[0] <= n_win_new;
        end
    end

    // gradients of one input
    logic signed [9:0]  ta_two, ta_one, ta_cur;
    logic signed [10:0] ta_two_x, ta_one_x, ta_cur_x, gx_top, gx_mid;
    logic [7:0]         sa_two, sa_cur, sb_two, sb_cur;
    ssg_pkg::t_set      n_set;

    always_comb begin
        ta_two   = f_diff(r_win[2].two, r_win[0].two, r_s2_ctrl.col_ge2);
        ta_one   = f_diff(r_win[2].one, r_win[0].one, r_s2_ctrl.col_ge2);
        ta_cur   = f_diff(r_win[2].cur, r_win[0].cur, r_s2_ctrl.col_ge2);
        ta_two_x = {ta_two[9], ta_two};
        ta_one_x = {ta_one[9], ta_one};
        ta_cur_x = {ta_cur[9], ta_cur};
        gx_top   = (ta_one_x + ta_cur_x) <<< 1;
        gx_mid   = (ta_one_x <<< 1) + ta_two_x + ta_cur_x;
        sa_two   = f_smooth(r_win[2].two, r_win[1].two, r_win[0].two, r_s2_ctrl.col_is1);
        sa_cur   = f_smooth(r_win[2].cur, r_win[1].cur, r_win[0].cur, r_s2_ctrl.col_is1);
        sb_two   = f_pair(r_win[1].two, r_win[0].two);
        sb_cur   = f_pair(r_win[1].cur, r_win[0].cur);

        n_set.gx_upper = r_s2_ctrl.top ? gx_top : gx_mid;
        n_set.gx_lower = gx_top;
        n_set.gy_upper = r_s2_ctrl.top ? 9'sd0 : f_sdiff(sa_cur, sa_two);
        n_set.gy_edge  = r_s2_ctrl.top ? 9'sd0 : f_sdiff(sb_cur, sb_two);
        n_set.row      = r_s2_ctrl.row;
        n_set.col      = r_s2_ctrl.col;
        n_set.mask     = r_s2_ctrl.mask;
    end

    // result set queue
    ssg_pkg::t_set  r_q [ssg_pkg::Q_DEPTH];
    ssg_pkg::t_set  head;
    logic [QAW-1:0] r_q_wr, r_q_rd;
    logic [NR-1:0]  r_taken, remain, sel;
    logic           q_push, q_pop, out_load, sel_last;
    logic           r_m_valid, r_m_last;

    assign head     = r_q[r_q_rd];
    assign remain   = head.mask & ~r_taken;
    assign sel      = remain & (~remain + 1'b1);
    assign sel_last = (remain & ~sel) == '0;
    assign q_push   = r_s2_valid & (r_s2_ctrl.mask != '0);
    assign out_load = (r_q_count != '0) & (~r_m_valid | i_m_axis_tready);
    assign q_pop    = out_load & sel_last;

    always_ff @(posedge i_clk) begin
        if (q_push) begin
            r_q[r_q_wr] <= n_set;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_wr    <= '0;
            r_q_rd    <= '0;
            r_q_count <= '0;
            r_taken   <= '0;
        end else begin
            if (q_push) begin
                r_q_wr <= r_q_wr + 1'b1;
            end
            if (q_pop) begin
                r_q_rd  <= r_q_rd + 1'b1;
                r_taken <= '0;
            end else if (out_load) begin
                r_taken <= r_taken | sel;
            end
            r_q_count <= r_q_count + QCW'(q_push) - QCW'(q_pop);
        end
    end

    // output register
    logic signed [ssg_pkg::GX_W-1:0] n_gx, r_m_gx;
    logic signed [ssg_pkg::GY_W-1:0] n_gy, r_m_gy;
    logic [PW-1:0]                   n_row, n_col, r_m_row, r_m_col;

    always_comb begin
        n_gx  = '0;
        n_gy  = '0;
        n_row = head.row;
        n_col = head.col;
        if (sel[ssg_pkg::RES_UPPER]) begin
            n_gx  = head.gx_upper;
            n_gy  = head.gy_upper;
            n_row = head.row - 1'b1;
            n_col = head.col - 1'b1;
        end else if (sel[ssg_pkg::RES_UPPER_EDGE]) begin
            n_gy  = head.gy_edge;
            n_row = head.row - 1'b1;
        end else if (sel[ssg_pkg::RES_LOWER]) begin
            n_gx  = head.gx_lower;
            n_col = head.col - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_gx   <= n_gx;
            r_m_gy   <= n_gy;
            r_m_row  <= n_row;
            r_m_col  <= n_col;
            r_m_last <= sel_last;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tlast  = r_m_last;
    assign o_m_axis_tdata  = {{PAD_W{1'b0}}, r_m_col, r_m_row, r_m_gy, r_m_gx};

`ifndef SYNTHESIS
    a_line_ports_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && r_s1_valid) |-> (r_col != r_s1_col))
        else $error("line memory read and write hit the same column");

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        inflight <= QCW'(ssg_pkg::Q_DEPTH))
        else $error("set queue and pipeline exceed queue depth");

    a_run_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && !r_m_last) |-> (r_q_count != '0))
        else $error("result set left the queue before its last transaction");
`endif

endmodule

/* sim/tb_top.sv */
// Testbench for separable_sobel_gradients: drives pixel frames and register
// writes, predicts every gradient result and checks the output stream in order.
// Depends on ssg_pkg and the separable_sobel_gradients RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ssg_pkg::*;

    localparam int MAX_W          = 2048;
    localparam int MAX_H          = 2048;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RAND_ITEMS     = 320;
    localparam int CALM_ITEMS     = 50;

    typedef enum logic [1:0] {
        LN_TWO_ABOVE,
        LN_ABOVE,
        LN_CURRENT
    } t_line_sel;

    typedef enum logic {
        ROW_CFG,
        ROW_PIX
    } t_row_kind;

    typedef enum logic [1:0] {
        PIX_UNIFORM,
        PIX_EXTREME,
        PIX_SMOOTH,
        PIX_FLAT
    } t_pix_style;

    typedef struct packed {
        logic signed [GX_W-1:0] gx;
        logic signed [GY_W-1:0] gy;
        logic [POS_W-1:0]       row;
        logic [POS_W-1:0]       col;
        logic                   last_of_run;
    } t_grad_rec;

    typedef struct packed {
        t_row_kind              kind;
        t_cfg_index             idx;
        logic [CFG_W-1:0]       data;
        logic                   typed;
        logic signed [GX_W-1:0] exp_gx;
        logic signed [GY_W-1:0] exp_gy;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [PIX_W-1:0]      s_tdata = '0;
    logic                  m_tready = 1'b0;
    logic                  cfg_valid = 1'b0;
    t_cfg_index            cfg_index = CFG_IMAGE_WIDTH;
    logic [CFG_W-1:0]      cfg_data = '0;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  o_m_axis_tlast;
    logic                  o_cfg_ready;

    // predictor state
    logic [PIX_W-1:0] row_above [MAX_W];
    logic [PIX_W-1:0] row_two_above [MAX_W];
    logic [15:0]      prev_pix = '0;
    logic [PIX_W-1:0] cur_pix = '0;
    logic [CFG_W-1:0] cfg_width = CFG_W'(IMAGE_WIDTH_RST);
    logic [CFG_W-1:0] cfg_height = CFG_W'(IMAGE_HEIGHT_RST);
    int               col_pos = 0;
    int               row_pos = 0;

    t_grad_rec step_grads [$];
    t_grad_rec awaited_grads [$];
    int        mismatches = 0;
    int        quiet_cycles = 0;
    int        stall_left = 0;
    bit        idle_on = 1'b1;
    logic [PIX_W-1:0] walk_pix = '0;

    t_dir_row directed [26] = '{
        '{ROW_CFG, CFG_IMAGE_WIDTH,  12'd0,   1'b0, 11'sd0, 9'sd0},
        '{ROW_CFG, CFG_IMAGE_HEIGHT, 12'd1,   1'b0, 11'sd0, 9'sd0},
        '{ROW_PIX, CFG_IMAGE_WIDTH,  12'd255, 1'b1, 11'sd0, 9'sd0},
        '{ROW_PIX, CFG_IMAGE_WIDTH,  12'd0,   1'b1, 11'sd0, 9'sd0},
        '{ROW_PIX, CFG_IMAGE_WIDTH,  12'd0,   1'b1, 11'sd0, 9'sd0},
        '{ROW_PIX, CFG_IMAGE_WIDTH,  12'd255, 1'b1, 11'sd0, 9'sd0},
        '{ROW_CFG, CFG_IMAGE_WIDTH,  12'd3,   1'b0, 11'sd0, 9'sd0},
        '{ROW_CFG, CFG_IMAGE_HEIGHT, 12'd3,   1'b0, 11'sd0, 9'sd0},
        '{ROW_PIX, CFG_IMAGE_WIDTH,  12'd0,   1'b0, 11'sd0, 9'sd0},
        '{ROW_PIX, CFG_IMAGE_WIDTH,  12'd0,   1'b0, 11'sd0, 9'sd0},
        '{ROW_PIX, CFG_IMAGE_WIDTH,  12'd255, 1'b0, 11'sd0, 9'sd0},
        '{ROW_PIX, CFG_IMAGE_WIDTH,  12'd0,   1'b0, 11'sd0, 9'sd0},
        '{ROW_PIX, CFG_IMAGE_WIDTH,  12'd128, 1'b0, 11'sd0, 9'sd0},
        '{ROW_PIX, CFG_IMAGE_WIDTH,  12'd255, 1'b0, 11'sd0, 9'sd0},
        '{ROW_PIX, CFG_IMAGE_WIDTH,  12'd255, 1'b0, 11'sd0, 9'sd0},
        '{ROW_PIX, CFG_IMAGE_WIDTH,  12'd255, 1'b0, 11'sd0, 9'sd0},
        '{ROW_PIX, CFG_IMAGE_WIDTH,  12'd255, 1'b0, 11'sd0, 9'sd0},
        '{ROW_PIX, CFG_IMAGE_WIDTH,  12'd255, 1'b0, 11'sd0, 9'sd0},
        '{ROW_PIX, CFG_IMAGE_WIDTH,  12'd255, 1'b0, 11'sd0, 9'sd0},
        '{ROW_PIX, CFG_IMAGE_WIDTH,  12'd0,   1'b0, 11'sd0, 9'sd0},
        '{ROW_PIX, CFG_IMAGE_WIDTH,  12'd255, 1'b0, 11'sd0, 9'sd0},
        '{ROW_PIX, CFG_IMAGE_WIDTH,  12'd0,   1'b0, 11'sd0, 9'sd0},
        '{ROW_PIX, CFG_IMAGE_WIDTH,  12'd0,   1'b0, 11'sd0, 9'sd0},
        '{ROW_PIX, CFG_IMAGE_WIDTH,  12'd0,   1'b0, 11'sd0, 9'sd0},
        '{ROW_PIX, CFG_IMAGE_WIDTH,  12'd0,   1'b0, 11'sd0, 9'sd0},
        '{ROW_PIX, CFG_IMAGE_WIDTH,  12'd0,   1'b0, 11'sd0, 9'sd0}
    };

    separable_sobel_gradients #(
        .MAX_WIDTH (MAX_W),
        .MAX_HEIGHT(MAX_H)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (s_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tlast (o_m_axis_tlast),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic int clamp_dim(logic [CFG_W-1:0] val, int hi);
        int v;
        v = int'(val);
        if (v < MIN_DIM) return MIN_DIM;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int pix_at(t_line_sel sel, int col);
        if (col < 0 || col >= MAX_W) return 0;
        case (sel)
            LN_TWO_ABOVE: return int'(row_two_above[col]);
            LN_ABOVE:     return int'(row_above[col]);
            default: begin
                if (col == col_pos) return int'(cur_pix);
                if (col == col_pos - 1) return int'(prev_pix[7:0]);
                if (col == col_pos - 2) return int'(prev_pix[15:8]);
                return 0;
            end
        endcase
    endfunction

    function automatic int hdiff(t_line_sel sel, int c, int lastc);
        if (c > 0 && c < lastc) return pix_at(sel, c + 1) - pix_at(sel, c - 1);
        return 0;
    endfunction

    function automatic int hsmooth(t_line_sel sel, int c, int lastc);
        int mid;
        mid = 2 * pix_at(sel, c);
        if (c <= 0) return (mid + 2 * pix_at(sel, c + 1)) / 4;
        if (c >= lastc) return (mid + 2 * pix_at(sel, c - 1)) / 4;
        return (mid + pix_at(sel, c - 1) + pix_at(sel, c + 1)) / 4;
    endfunction

    function automatic void add_gradient(int row, int c, int lastc, t_line_sel up,
                                         t_line_sel mid, t_line_sel down,
                                         bit has_up, bit has_down);
        int        gx;
        int        gy;
        int        tm;
        t_grad_rec rec;
        tm = hdiff(mid, c, lastc);
        if (!has_up)
            gx = 2 * tm + 2 * hdiff(down, c, lastc);
        else if (!has_down)
            gx = 2 * tm + 2 * hdiff(up, c, lastc);
        else
            gx = 2 * tm + hdiff(up, c, lastc) + hdiff(down, c, lastc);
        gy = (has_up && has_down) ? hsmooth(down, c, lastc) - hsmooth(up, c, lastc) : 0;
        rec.gx          = gx[GX_W-1:0];
        rec.gy          = gy[GY_W-1:0];
        rec.row         = row[POS_W-1:0];
        rec.col         = c[POS_W-1:0];
        rec.last_of_run = 1'b0;
        step_grads = {step_grads, rec};
    endfunction

    function automatic void store_column(int col, logic [PIX_W-1:0] val);
        if (col < 0 || col >= MAX_W) return;
        row_two_above[col] = row_above[col];
        row_above[col]     = val;
    endfunction

    function automatic void predict_gradients(logic [PIX_W-1:0] pix);
        int w;
        int h;
        int c;
        int r;
        int lastc;
        bit row_end;
        bit last_row;
        w        = clamp_dim(cfg_width, MAX_W);
        h        = clamp_dim(cfg_height, MAX_H);
        cur_pix  = pix;
        c        = col_pos;
        r        = row_pos;
        row_end  = c >= w - 1;
        last_row = r >= h - 1;
        lastc    = row_end ? c : w - 1;
        step_grads.delete();
        if (r >= 1) begin
            if (c >= 1)
                add_gradient(r - 1, c - 1, lastc, LN_TWO_ABOVE, LN_ABOVE, LN_CURRENT,
                             r != 1, 1'b1);
            if (row_end)
                add_gradient(r - 1, c, lastc, LN_TWO_ABOVE, LN_ABOVE, LN_CURRENT,
                             r != 1, 1'b1);
            if (last_row) begin
                if (c >= 1)
                    add_gradient(r, c - 1, lastc, LN_ABOVE, LN_CURRENT, LN_CURRENT,
                                 1'b1, 1'b0);
                if (row_end)
                    add_gradient(r, c, lastc, LN_ABOVE, LN_CURRENT, LN_CURRENT,
                                 1'b1, 1'b0);
            end
        end
        if (step_grads.size() > 0) step_grads[step_grads.size() - 1].last_of_run = 1'b1;
        store_column(c - 2, prev_pix[15:8]);
        if (row_end) begin
            store_column(c - 1, prev_pix[7:0]);
            store_column(c, pix);
        end
        prev_pix = {prev_pix[7:0], pix};
        if (row_end) begin
            col_pos = 0;
            row_pos = last_row ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel(t_pix_style style);
        int v;
        case (style)
            PIX_EXTREME: walk_pix = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            PIX_SMOOTH: begin
                v = int'(walk_pix) + $urandom_range(0, 24) - 12;
                walk_pix = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
            end
            PIX_FLAT:   if ($urandom_range(0, 15) == 0) walk_pix = 8'($urandom_range(0, 255));
            default:    walk_pix = 8'($urandom_range(0, 255));
        endcase
        return walk_pix;
    endfunction

    task automatic note_mismatch(string what, t_grad_rec want, t_grad_rec got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t %s: exp gx=%0d gy=%0d row=%0d col=%0d last=%0b",
                     $realtime, what, want.gx, want.gy, want.row, want.col,
                     want.last_of_run);
            $display("    got gx=%0d gy=%0d row=%0d col=%0d last=%0b",
                     got.gx, got.gy, got.row, got.col, got.last_of_run);
        end
    endtask

    task automatic send_pixel(logic [PIX_W-1:0] pix, logic typed,
                              logic signed [GX_W-1:0] tgx, logic signed [GY_W-1:0] tgy);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_gradients(pix);
        foreach (step_grads[k]) begin
            if (typed) begin
                step_grads[k].gx = tgx;
                step_grads[k].gy = tgy;
            end
            awaited_grads = {awaited_grads, step_grads[k]};
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (awaited_grads.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_index idx, logic [CFG_W-1:0] val);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_IMAGE_WIDTH)
            cfg_width = val;
        else
            cfg_height = val;
    endtask

    task automatic send_frame_rest(t_pix_style style, inout int sent);
        do begin
            send_pixel(pick_pixel(style), 1'b0, '0, '0);
            sent++;
        end while (!(row_pos == 0 && col_pos == 0));
    endtask

    // output side: random stall bursts, none once the run calms down
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= (stall_left == 1);
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(1, 6);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_grad_rec got;
        t_grad_rec want;
        if (i_rst_n && o_m_axis_tvalid && m_tready) begin
            got.gx          = o_m_axis_tdata[GX_W-1:0];
            got.gy          = o_m_axis_tdata[GX_W+GY_W-1:GX_W];
            got.row         = o_m_axis_tdata[GX_W+GY_W+POS_W-1:GX_W+GY_W];
            got.col         = o_m_axis_tdata[OUT_PAY_W-1:GX_W+GY_W+POS_W];
            got.last_of_run = o_m_axis_tlast;
            if (awaited_grads.size() == 0) begin
                note_mismatch("unexpected result", '0, got);
            end else begin
                want = awaited_grads.pop_front();
                if (got.gx !== want.gx || got.gy !== want.gy || got.row !== want.row
                    || got.col !== want.col || got.last_of_run !== want.last_of_run)
                    note_mismatch("result mismatch", want, got);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && m_tready)
            || (cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int         rand_sent;
        int         extra_sent;
        int         pick;
        int         cur_w;
        t_pix_style style;
        rand_sent  = 0;
        extra_sent = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) begin
            if (directed[k].kind == ROW_CFG)
                write_reg(directed[k].idx, directed[k].data);
            else
                send_pixel(directed[k].data[PIX_W-1:0], directed[k].typed,
                           directed[k].exp_gx, directed[k].exp_gy);
        end

        // widest and tallest settings from out-of-range values, cut short mid-frame
        write_reg(CFG_IMAGE_WIDTH, 12'hFFF);
        write_reg(CFG_IMAGE_HEIGHT, 12'hFFF);
        repeat (24) begin
            send_pixel(pick_pixel(PIX_UNIFORM), 1'b0, '0, '0);
            extra_sent++;
        end
        write_reg(CFG_IMAGE_WIDTH, 12'd4);
        repeat (9) begin
            send_pixel(pick_pixel(PIX_SMOOTH), 1'b0, '0, '0);
            extra_sent++;
        end
        write_reg(CFG_IMAGE_HEIGHT, 12'd0);
        send_frame_rest(PIX_SMOOTH, extra_sent);

        while (rand_sent < RAND_ITEMS) begin
            idle_on = (rand_sent < RAND_ITEMS - CALM_ITEMS);
            pick    = $urandom_range(0, 9);
            style   = t_pix_style'($urandom_range(0, 3));
            if (row_pos == 0 && col_pos == 0) begin
                if ($urandom_range(0, 3) != 0) begin
                    pick = $urandom_range(0, 19);
                    write_reg(CFG_IMAGE_WIDTH, (pick == 0) ? 12'($urandom_range(0, 1)) :
                              (pick < 4) ? 12'($urandom_range(9, 32)) :
                              12'($urandom_range(2, 8)));
                end
                if ($urandom_range(0, 3) != 0) begin
                    pick = $urandom_range(0, 19);
                    write_reg(CFG_IMAGE_HEIGHT, (pick == 0) ? 12'($urandom_range(0, 1)) :
                              (pick < 3) ? 12'($urandom_range(9, 12)) :
                              12'($urandom_range(2, 6)));
                end
                pick = $urandom_range(0, 9);
            end else if (pick < 3) begin
                // mid-frame geometry change: width may only shrink
                cur_w = clamp_dim(cfg_width, MAX_W);
                if ($urandom_range(0, 1))
                    write_reg(CFG_IMAGE_HEIGHT, 12'($urandom_range(0, 10)));
                else
                    write_reg(CFG_IMAGE_WIDTH, 12'($urandom_range(0, cur_w)));
            end
            if (pick < 8) begin
                send_frame_rest(style, rand_sent);
            end else begin
                repeat ($urandom_range(1, 20)) begin
                    send_pixel(pick_pixel(style), 1'b0, '0, '0);
                    rand_sent++;
                end
            end
        end

        idle_on = 1'b0;
        s_tvalid <= 1'b0;
        while (awaited_grads.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* separable_sobel_gradients.f */
hw/rtl/ssg_pkg.sv
hw/rtl/separable_sobel_gradients.sv
sim/tb_top.sv
